// ----- hw/rtl/jqc_pkg.sv -----
package jqc_pkg;

    localparam int DEPTH    = 16;
    localparam int ID_WIDTH = 16;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OCC_W    = 5;

    typedef logic [1:0]          op_t;
    typedef logic [1:0]          stat_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [ID_WIDTH-1:0] id_t;

    localparam op_t OP_ADD    = 2'd0;
    localparam op_t OP_PROC   = 2'd1;
    localparam op_t OP_CANCEL = 2'd2;

    localparam stat_t STAT_OK        = 2'd0;
    localparam stat_t STAT_FULL      = 2'd1;
    localparam stat_t STAT_EMPTY     = 2'd2;
    localparam stat_t STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic  load;
        logic  add;
        logic  set_stat;
        stat_t stat;
        logic  rd_head;
        logic  rd_next;
        logic  take;
        logic  srch_init;
        logic  srch_step;
        logic  sh_write;
        logic  cancel_done;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic match;
        logic last;
        logic at_tail;
        logic out_free;
    } sts_t;

    function automatic addr_t wrap_next(addr_t i);
        addr_t r;
        if (i == addr_t'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + addr_t'(1);
        end
        return r;
    endfunction

    function automatic addr_t wrap_prev(addr_t i);
        addr_t r;
        if (i == '0) begin
            r = addr_t'(DEPTH - 1);
        end else begin
            r = i - addr_t'(1);
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/jqc_ram.sv -----
module jqc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/jqc_ctrl.sv -----
module jqc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  jqc_pkg::sts_t sts,
    output jqc_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_PROC = 4'd2;
    localparam logic [3:0] S_SRD  = 4'd3;
    localparam logic [3:0] S_SCMP = 4'd4;
    localparam logic [3:0] S_SHRD = 4'd5;
    localparam logic [3:0] S_SHWR = 4'd6;
    localparam logic [3:0] S_RESP = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.set_stat = 1'b1;
                cmd.stat     = jqc_pkg::STAT_OK;
                state_next   = S_RESP;
                case (sts.op)
                    jqc_pkg::OP_ADD: begin
                        if (sts.full) begin
                            cmd.stat = jqc_pkg::STAT_FULL;
                        end else begin
                            cmd.add = 1'b1;
                        end
                    end
                    jqc_pkg::OP_PROC: begin
                        if (sts.empty) begin
                            cmd.stat = jqc_pkg::STAT_EMPTY;
                        end else begin
                            cmd.set_stat = 1'b0;
                            cmd.rd_head  = 1'b1;
                            state_next   = S_PROC;
                        end
                    end
                    jqc_pkg::OP_CANCEL: begin
                        if (sts.empty) begin
                            cmd.stat = jqc_pkg::STAT_EMPTY;
                        end else begin
                            cmd.set_stat  = 1'b0;
                            cmd.srch_init = 1'b1;
                            state_next    = S_SRD;
                        end
                    end
                    default: begin
                        cmd.stat = jqc_pkg::STAT_OK;
                    end
                endcase
            end
            S_PROC: begin
                cmd.take     = 1'b1;
                cmd.set_stat = 1'b1;
                cmd.stat     = jqc_pkg::STAT_OK;
                state_next   = S_RESP;
            end
            S_SRD: begin
                state_next = S_SCMP;
            end
            S_SCMP: begin
                if (sts.match) begin
                    state_next = S_SHRD;
                end else if (sts.last) begin
                    cmd.set_stat = 1'b1;
                    cmd.stat     = jqc_pkg::STAT_NOT_FOUND;
                    state_next   = S_RESP;
                end else begin
                    cmd.srch_step = 1'b1;
                    state_next    = S_SRD;
                end
            end
            S_SHRD: begin
                if (sts.at_tail) begin
                    cmd.cancel_done = 1'b1;
                    cmd.set_stat    = 1'b1;
                    cmd.stat        = jqc_pkg::STAT_OK;
                    state_next      = S_RESP;
                end else begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHWR;
                end
            end
            S_SHWR: begin
                cmd.sh_write = 1'b1;
                state_next   = S_SHRD;
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_load_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == S_EXEC)
        else $error("load not followed by exec");

    a_out_only_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> s_ready)
        else $error("result load did not return to idle");

    a_shwr_from_shrd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sh_write |-> $past(cmd.rd_next))
        else $error("shift write without prior read");

endmodule

// ----- hw/rtl/jqc_dp.sv -----
module jqc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  jqc_pkg::cmd_t                       cmd,
    output jqc_pkg::sts_t                       sts,
    input  logic [1:0]                          s_operation,
    input  logic [jqc_pkg::ID_WIDTH-1:0]        s_job_id,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [jqc_pkg::ID_WIDTH-1:0]        m_removed_id,
    output logic [jqc_pkg::OCC_W-1:0]           m_occupancy
);

    jqc_pkg::addr_t head_reg;
    jqc_pkg::addr_t tail_reg;
    jqc_pkg::addr_t pos_reg;
    jqc_pkg::cnt_t  count_reg;
    jqc_pkg::cnt_t  n_reg;
    jqc_pkg::op_t   op_reg;
    jqc_pkg::id_t   id_reg;
    jqc_pkg::id_t   removed_reg;
    jqc_pkg::stat_t stat_reg;

    logic                          m_valid_reg;
    jqc_pkg::stat_t                m_status_reg;
    jqc_pkg::id_t                  m_removed_reg;
    logic [jqc_pkg::OCC_W-1:0]     m_occ_reg;

    logic           ram_we;
    jqc_pkg::addr_t ram_waddr;
    jqc_pkg::id_t   ram_wdata;
    jqc_pkg::addr_t ram_raddr;
    jqc_pkg::id_t   ram_rdata;

    always_comb begin
        ram_we    = cmd.add | cmd.sh_write;
        ram_waddr = cmd.add ? jqc_pkg::wrap_next(tail_reg) : pos_reg;
        ram_wdata = cmd.add ? id_reg : ram_rdata;
        if (cmd.rd_head) begin
            ram_raddr = head_reg;
        end else if (cmd.rd_next) begin
            ram_raddr = jqc_pkg::wrap_next(pos_reg);
        end else begin
            ram_raddr = pos_reg;
        end
    end

    jqc_ram #(
        .WIDTH (jqc_pkg::ID_WIDTH),
        .DEPTH (jqc_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= jqc_pkg::addr_t'(jqc_pkg::DEPTH - 1);
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.add) begin
                tail_reg  <= jqc_pkg::wrap_next(tail_reg);
                count_reg <= count_reg + jqc_pkg::cnt_t'(1);
            end
            if (cmd.take) begin
                head_reg  <= jqc_pkg::wrap_next(head_reg);
                count_reg <= count_reg - jqc_pkg::cnt_t'(1);
            end
            if (cmd.cancel_done) begin
                tail_reg  <= jqc_pkg::wrap_prev(tail_reg);
                count_reg <= count_reg - jqc_pkg::cnt_t'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_operation;
            id_reg      <= s_job_id;
            removed_reg <= '0;
        end
        if (cmd.take) begin
            removed_reg <= ram_rdata;
        end
        if (cmd.set_stat) begin
            stat_reg <= cmd.stat;
        end
        if (cmd.srch_init) begin
            pos_reg <= head_reg;
            n_reg   <= '0;
        end
        if (cmd.srch_step || cmd.sh_write) begin
            pos_reg <= jqc_pkg::wrap_next(pos_reg);
        end
        if (cmd.srch_step) begin
            n_reg <= n_reg + jqc_pkg::cnt_t'(1);
        end
        if (cmd.out_load) begin
            m_status_reg  <= stat_reg;
            m_removed_reg <= removed_reg;
            m_occ_reg     <= jqc_pkg::OCC_W'(count_reg);
        end
    end

    always_comb begin
        sts.op       = op_reg;
        sts.full     = (count_reg >= jqc_pkg::cnt_t'(jqc_pkg::DEPTH));
        sts.empty    = (count_reg == '0);
        sts.match    = (ram_rdata == id_reg);
        sts.last     = (n_reg == count_reg - jqc_pkg::cnt_t'(1));
        sts.at_tail  = (pos_reg == tail_reg);
        sts.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_removed_id = m_removed_reg;
    assign m_occupancy  = m_occ_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= jqc_pkg::cnt_t'(jqc_pkg::DEPTH))
        else $error("occupancy above depth");

    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.add |=> count_reg == $past(count_reg) + jqc_pkg::cnt_t'(1))
        else $error("add did not grow occupancy");

    a_take_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> count_reg != '0)
        else $error("take from empty queue");

    a_shift_before_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sh_write |-> pos_reg != tail_reg)
        else $error("shift past tail");

endmodule

// ----- hw/rtl/job_queue_with_cancel.sv -----
// job queue with cancel: circular queue of 16 job identifiers
// input word: s_operation (0 add, 1 process head, 2 cancel by id) and s_job_id,
// taken when s_valid and s_ready are both high
// result word: m_status (0 ok, 1 full, 2 empty, 3 not found), m_removed_id
// (head id on a successful process, else 0) and m_occupancy after the operation
// one result word per input word, in order
// one word is worked at a time; s_ready is high only while the block is idle
// add and unknown codes: execute, then result; process: read head, take, result
// cancel: compares entries from the head until the id is found, then moves each
// later entry up one place in the entry memory (one write port, registered read)
// a result sits in the output register until taken; while m_ready is low the
// block holds the next result and stops accepting after one more word
// reset (aresetn low, synchronous) empties the queue and drops any result;
// the block accepts a word in the first cycle after reset
module job_queue_with_cancel (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_operation,
    input  logic [jqc_pkg::ID_WIDTH-1:0] s_job_id,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [jqc_pkg::ID_WIDTH-1:0] m_removed_id,
    output logic [jqc_pkg::OCC_W-1:0]    m_occupancy
);

    jqc_pkg::cmd_t cmd;
    jqc_pkg::sts_t sts;

    jqc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    jqc_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_operation  (s_operation),
        .s_job_id     (s_job_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_removed_id (m_removed_id),
        .m_occupancy  (m_occupancy)
    );

endmodule
